// ===== design/cartridge_bank_controller_defines.svh =====
// Assertion macros shared by the cartridge bank controller RTL.
// Relies on i_clk and i_rst_n being visible where the macros are used.
`ifndef CARTRIDGE_BANK_CONTROLLER_DEFINES_SVH
`define CARTRIDGE_BANK_CONTROLLER_DEFINES_SVH

// same-cycle implication, gated off while in reset
`define CBC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cbc: same-cycle check failed");

// next-cycle implication, gated off while in reset
`define CBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cbc: next-cycle check failed");

`endif

// ===== design/cbc_pkg.sv =====
// Package for the cartridge bank controller: types, codes and constants.
// No dependencies.
package cbc_pkg;

    // bank limits
    localparam int unsigned MAX_ROM_BANKS = 512;
    localparam int unsigned MAX_RAM_BANKS = 16;

    // field widths
    localparam int unsigned ADDR_W     = 16;
    localparam int unsigned DATA_W     = 8;
    localparam int unsigned ROM_BANK_W = 9;
    localparam int unsigned RAM_BANK_W = 4;
    localparam int unsigned ROM_CNT_W  = 10;
    localparam int unsigned RAM_CNT_W  = 5;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 16;

    // shared divider: dividend width and step counts
    localparam int unsigned DIV_W     = 10;
    localparam int unsigned CNT_W     = 4;
    localparam int unsigned ROM_STEPS = 10;
    localparam int unsigned RAM_STEPS = 4;

    // controller kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_MBC1 = 2'd1;
    localparam logic [1:0] KIND_MBC3 = 2'd2;
    localparam logic [1:0] KIND_MBC5 = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KIND    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_CNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_CNT = 2'd2;

    // register regions, address bits [15:13]
    localparam logic [2:0] REG_RAM_EN   = 3'd0; // 0x0000-0x1FFF
    localparam logic [2:0] REG_ROM_BANK = 3'd1; // 0x2000-0x3FFF
    localparam logic [2:0] REG_RAM_BANK = 3'd2; // 0x4000-0x5FFF
    localparam logic [2:0] REG_MODE     = 3'd3; // 0x6000-0x7FFF

    localparam logic [3:0] RAM_EN_KEY = 4'hA;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROM,
        ST_RAM,
        ST_FIN,
        ST_OUT
    } t_cbc_state;

endpackage

// ===== design/cartridge_bank_controller.sv =====
// Cartridge bank controller: takes a CPU register write, returns the RAM enable
// and the selected ROM and RAM banks. Bank modulo runs on one shared
// shift-subtract divider. Each accepted word passes through 10 ROM divide steps,
// 4 RAM divide steps, one fixup and one output load; the load waits while the output stalls.
// Input is not ready while a word is in work.
// Synchronous active-low reset: kind none, 2 ROM banks, 0 RAM banks, ROM bank 1.
`include "cartridge_bank_controller_defines.svh"

module cartridge_bank_controller
    import cbc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // input words
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] write_addr, [23:16] write_data
    // result words
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [0] ram_enabled, [9:1] rom_bank_sel,
                                                  // [13:10] ram_bank_sel, [15:14] zero
);

    // config registers
    logic [1:0]           r_kind;
    logic [ROM_CNT_W-1:0] r_rom_cnt;
    logic [RAM_CNT_W-1:0] r_ram_cnt;

    // mapper state
    logic                  r_ram_on,   n_ram_on;
    logic [ROM_BANK_W-1:0] r_rom_cur,  n_rom_cur;
    logic [RAM_BANK_W-1:0] r_ram_cur,  n_ram_cur;
    logic [DATA_W-1:0]     r_low,      n_low;
    logic [1:0]            r_high,     n_high;
    logic                  r_mode,     n_mode;
    logic [RAM_BANK_W-1:0] r_latched,  n_latched;

    // sequencer and divider
    t_cbc_state            r_state,    n_state;
    logic                  r_rom_go,   n_rom_go;
    logic                  r_ram_go,   n_ram_go;
    logic                  r_ram_tgt,  n_ram_tgt;  // 1: latched register (MBC1)
    logic [RAM_BANK_W-1:0] r_ram_num,  n_ram_num;
    logic [DIV_W-1:0]      r_num,      n_num;
    logic [DIV_W-1:0]      r_rem,      n_rem;
    logic [DIV_W-1:0]      r_div,      n_div;
    logic [CNT_W-1:0]      r_cnt,      n_cnt;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    // input unpacking
    logic [ADDR_W-1:0]     in_addr;
    logic [DATA_W-1:0]     in_data;
    logic [2:0]            in_region;
    logic                  in_hi_addr;
    logic                  in_accept;

    // effective counts
    logic [ROM_CNT_W-1:0]  rom_eff;
    logic [RAM_CNT_W-1:0]  ram_eff;
    logic                  ram_nz;

    // divider step
    logic [DIV_W-1:0]      stp_t;
    logic                  stp_ge;
    logic [DIV_W-1:0]      stp_rem;

    logic [DIV_W-1:0]      rom_dvd;

    assign in_addr    = s_axis_tdata[ADDR_W-1:0];
    assign in_data    = s_axis_tdata[ADDR_W +: DATA_W];
    assign in_region  = in_addr[15:13];
    assign in_hi_addr = in_addr[12];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // zero or oversize ROM counts and oversize RAM counts clamp to the maximum
    always_comb begin
        if (r_rom_cnt == '0 || r_rom_cnt > ROM_CNT_W'(MAX_ROM_BANKS)) begin
            rom_eff = ROM_CNT_W'(MAX_ROM_BANKS);
        end else begin
            rom_eff = r_rom_cnt;
        end
        if (r_ram_cnt > RAM_CNT_W'(MAX_RAM_BANKS)) begin
            ram_eff = RAM_CNT_W'(MAX_RAM_BANKS);
        end else begin
            ram_eff = r_ram_cnt;
        end
        ram_nz = (ram_eff != '0);
    end

    // one restoring step: shift in next dividend bit, subtract if it fits
    assign stp_t   = {r_rem[DIV_W-2:0], r_num[DIV_W-1]};
    assign stp_ge  = (stp_t >= r_div);
    assign stp_rem = stp_ge ? (stp_t - r_div) : stp_t;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= KIND_NONE;
            r_rom_cnt <= ROM_CNT_W'(2);
            r_ram_cnt <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_KIND:    r_kind    <= i_cfg_data[1:0];
                CFG_ROM_CNT: r_rom_cnt <= i_cfg_data[ROM_CNT_W-1:0];
                CFG_RAM_CNT: r_ram_cnt <= i_cfg_data[RAM_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer, register updates and divider control
    always_comb begin
        n_state     = r_state;
        n_ram_on    = r_ram_on;
        n_rom_cur   = r_rom_cur;
        n_ram_cur   = r_ram_cur;
        n_low       = r_low;
        n_high      = r_high;
        n_mode      = r_mode;
        n_latched   = r_latched;
        n_rom_go    = r_rom_go;
        n_ram_go    = r_ram_go;
        n_ram_tgt   = r_ram_tgt;
        n_ram_num   = r_ram_num;
        n_num       = r_num;
        n_rem       = r_rem;
        n_div       = r_div;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        rom_dvd     = '0;

        // output register drains independently of the sequencer
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_rom_go  = 1'b0;
                    n_ram_go  = 1'b0;
                    n_ram_tgt = 1'b0;
                    n_ram_num = in_data[RAM_BANK_W-1:0];
                    // RAM enable, common to all mappers
                    if (r_kind != KIND_NONE && in_region == REG_RAM_EN) begin
                        n_ram_on = (in_data[3:0] == RAM_EN_KEY);
                    end
                    case (r_kind)
                        KIND_MBC1: begin
                            case (in_region)
                                REG_ROM_BANK: begin
                                    n_low = {3'b0, in_data[4:0]};
                                    if (in_data[4:0] == '0) begin
                                        n_low = DATA_W'(1);
                                    end
                                end
                                REG_RAM_BANK: begin
                                    n_high    = in_data[1:0];
                                    n_ram_go  = ram_nz;
                                    n_ram_tgt = 1'b1;
                                    n_ram_num = {2'b0, in_data[1:0]};
                                end
                                REG_MODE: n_mode = in_data[0];
                                default: ;
                            endcase
                            n_rom_go = 1'b1;
                            rom_dvd  = {2'b0, n_low} | {3'b0, n_high, 5'b0};
                        end
                        KIND_MBC3: begin
                            if (in_region == REG_ROM_BANK) begin
                                if (in_data[6:0] == '0) begin
                                    n_rom_cur = ROM_BANK_W'(1);
                                end else begin
                                    n_rom_go = 1'b1;
                                end
                            end
                            if (in_region == REG_RAM_BANK) begin
                                n_ram_go = ram_nz && (in_data <= DATA_W'(7));
                            end
                            rom_dvd = {3'b0, in_data[6:0]};
                        end
                        KIND_MBC5: begin
                            if (in_region == REG_ROM_BANK && !in_hi_addr) begin
                                n_low = in_data;
                            end
                            if (in_region == REG_ROM_BANK && in_hi_addr) begin
                                n_high = {1'b0, in_data[0]};
                            end
                            if (in_region == REG_RAM_BANK) begin
                                n_ram_go = ram_nz;
                            end
                            n_rom_go = 1'b1;
                            rom_dvd  = {n_high, n_low};
                        end
                        default: ;
                    endcase
                    // load divider for the ROM pass
                    n_num   = rom_dvd;
                    n_rem   = '0;
                    n_div   = rom_eff;
                    n_cnt   = '0;
                    n_state = ST_ROM;
                end
            end

            ST_ROM: begin
                n_rem = stp_rem;
                n_num = {r_num[DIV_W-2:0], 1'b0};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(ROM_STEPS - 1)) begin
                    if (r_rom_go) begin
                        n_rom_cur = stp_rem[ROM_BANK_W-1:0];
                    end
                    // load divider for the RAM pass, dividend in the top bits
                    n_num   = {r_ram_num, {(DIV_W-RAM_BANK_W){1'b0}}};
                    n_rem   = '0;
                    n_div   = {{(DIV_W-RAM_CNT_W){1'b0}}, ram_eff};
                    n_cnt   = '0;
                    n_state = ST_RAM;
                end
            end

            ST_RAM: begin
                n_rem = stp_rem;
                n_num = {r_num[DIV_W-2:0], 1'b0};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(RAM_STEPS - 1)) begin
                    if (r_ram_go && r_ram_tgt) begin
                        n_latched = stp_rem[RAM_BANK_W-1:0];
                    end else if (r_ram_go) begin
                        n_ram_cur = stp_rem[RAM_BANK_W-1:0];
                    end
                    n_state = ST_FIN;
                end
            end

            ST_FIN: begin
                // MBC1 shows the latched RAM bank only in mode 1
                if (r_kind == KIND_MBC1) begin
                    n_ram_cur = r_mode ? r_latched : '0;
                end
                n_state = ST_OUT;
            end

            ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {2'b0, r_ram_cur, r_rom_cur, r_ram_on};
                    n_state     = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // control and mapper state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_ram_on    <= 1'b0;
            r_rom_cur   <= ROM_BANK_W'(1);
            r_ram_cur   <= '0;
            r_low       <= DATA_W'(1);
            r_high      <= '0;
            r_mode      <= 1'b0;
            r_latched   <= '0;
            r_rom_go    <= 1'b0;
            r_ram_go    <= 1'b0;
            r_ram_tgt   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_ram_on    <= n_ram_on;
            r_rom_cur   <= n_rom_cur;
            r_ram_cur   <= n_ram_cur;
            r_low       <= n_low;
            r_high      <= n_high;
            r_mode      <= n_mode;
            r_latched   <= n_latched;
            r_rom_go    <= n_rom_go;
            r_ram_go    <= n_ram_go;
            r_ram_tgt   <= n_ram_tgt;
        end
    end

    // divider datapath and output payload
    always_ff @(posedge i_clk) begin
        r_ram_num  <= n_ram_num;
        r_num      <= n_num;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_cnt      <= n_cnt;
        r_out_data <= n_out_data;
    end

    // accepted word starts a fresh ROM pass
    `CBC_ASSERT_NEXT(a_accept_starts_rom, in_accept, r_state == ST_ROM && r_cnt == '0)
    // ROM pass hands over to the RAM pass after its last step
    `CBC_ASSERT_NEXT(a_rom_to_ram, r_state == ST_ROM && r_cnt == CNT_W'(ROM_STEPS - 1),
                     r_state == ST_RAM && r_cnt == '0)
    // partial remainder stays below the ROM divisor
    `CBC_ASSERT_NOW(a_rom_rem_bound, r_state == ST_ROM, r_rem < r_div)

endmodule
